### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge
`define VIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define VIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define VIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/vic_pkg.sv
// ----------------------------------------------------------------------------
// vic_pkg
// Shared constants and types of the vectored interrupt controller.
// ----------------------------------------------------------------------------
package vic_pkg;

  // Default sizes
  localparam int NUM_LINES_DEF = 32;
  localparam int NUM_SLOTS_DEF = 16;

  // Slot index width, enough for the default slot count
  localparam int SLOT_IDX_W = 4;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_LINE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  // Register word indexes (byte offset >> 2)
  localparam logic [9:0] W_IRQ_STATUS   = 10'd0;
  localparam logic [9:0] W_FIQ_STATUS   = 10'd1;
  localparam logic [9:0] W_RAW_INTR     = 10'd2;
  localparam logic [9:0] W_INT_SELECT   = 10'd3;
  localparam logic [9:0] W_INT_ENABLE   = 10'd4;
  localparam logic [9:0] W_INT_EN_CLEAR = 10'd5;
  localparam logic [9:0] W_SOFT_INT     = 10'd6;
  localparam logic [9:0] W_SOFT_CLEAR   = 10'd7;
  localparam logic [9:0] W_PROTECTION   = 10'd8;
  localparam logic [9:0] W_VECT_ADDR    = 10'd12;
  localparam logic [9:0] W_DEF_VECT     = 10'd13;

  // Address windows
  localparam logic [11:0] ID_BASE        = 12'hFE0;
  localparam logic [3:0]  SLOT_ADDR_PAGE = 4'h1;
  localparam logic [3:0]  SLOT_CTL_PAGE  = 4'h2;

  // Slot control byte: enable bit, source select in bits 4..0
  localparam int CTL_EN_BIT = 5;

  // Peripheral ID bytes, one per word
  localparam logic [7:0] ID_BYTES [8] = '{
    8'h90, 8'h11, 8'h04, 8'h00, 8'h0D, 8'hF0, 8'h05, 8'hB1
  };

  // First-hit token carried down the slot chain
  typedef struct packed {
    logic                  found;
    logic [SLOT_IDX_W-1:0] idx;
  } hit_t;

endpackage

### hw/rtl/vic_cell.sv
// ----------------------------------------------------------------------------
// vic_cell
// One vector slot: holds its control byte, adds its source to the running
// priority mask and passes the mask and first pending hit to the next slot.
// ----------------------------------------------------------------------------
module vic_cell #(
  parameter int NUM_LINES = vic_pkg::NUM_LINES_DEF,
  parameter int CELL_ID   = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ctl_we,
  input  logic [7:0]           ctl_wdata,
  input  logic [NUM_LINES-1:0] pending,
  input  logic [NUM_LINES-1:0] acc_in,
  input  vic_pkg::hit_t        hit_in,
  output logic [NUM_LINES-1:0] acc_out,
  output vic_pkg::hit_t        hit_out,
  output logic [7:0]           ctl_out
);

  localparam logic [NUM_LINES-1:0] LINE_ONE = NUM_LINES'(1);

  logic [7:0]           ctl_r, ctl_nxt;
  logic [NUM_LINES-1:0] acc_r, acc_nxt;
  vic_pkg::hit_t        hit_r, hit_nxt;
  logic [NUM_LINES-1:0] src_bit;

  // Source bit of this slot; a source beyond the line count matches nothing
  assign src_bit = (ctl_r[vic_pkg::CTL_EN_BIT] && (int'(ctl_r[4:0]) < NUM_LINES)) ?
                   (LINE_ONE << ctl_r[4:0]) : '0;

  // Mask of this slot's level and the ones above
  assign acc_nxt = acc_in | src_bit;
  assign ctl_nxt = ctl_we ? ctl_wdata : ctl_r;

  // First level whose mask meets a pending line
  always_comb begin
    hit_nxt = hit_in;
    if (!hit_in.found && (|(pending & acc_nxt))) begin
      hit_nxt.found = 1'b1;
      hit_nxt.idx   = vic_pkg::SLOT_IDX_W'(CELL_ID);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
      acc_r <= '0;
      hit_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
      acc_r <= acc_nxt;
      hit_r <= hit_nxt;
    end
  end

  assign acc_out = acc_r;
  assign hit_out = hit_r;
  assign ctl_out = ctl_r;

endmodule

### hw/rtl/vic_addr_mem.sv
// ----------------------------------------------------------------------------
// vic_addr_mem
// Vector address store: one write port, one registered read port, with a
// valid bit per entry so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module vic_addr_mem #(
  parameter int DEPTH = vic_pkg::NUM_SLOTS_DEF + 1,
  parameter int AW    = $clog2(vic_pkg::NUM_SLOTS_DEF + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [31:0]    rdata_r;

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= valid_r[raddr] ? mem[raddr] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/vectored_interrupt_controller.sv
// ----------------------------------------------------------------------------
// vectored_interrupt_controller: NUM_SLOTS-slot vectored interrupt controller
// Sequence: an accepted item passes apply, sweep down the slot chain, exec and finish;
// its result is registered once the output is free; a new item is taken only in idle.
// Reset: synchronous; control and interrupt state clear, vectors read as zero, level goes idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vectored_interrupt_controller #(
  parameter int NUM_LINES = vic_pkg::NUM_LINES_DEF,
  parameter int NUM_SLOTS = vic_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [4:0]  in_line_index,
  input  logic        in_line_level,
  input  logic [11:0] in_byte_offset,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_irq_out,
  output logic        out_fiq_out
);

  localparam int NUM_LEVELS = NUM_SLOTS + 1;
  localparam int AW         = $clog2(NUM_LEVELS);
  localparam int LVL_W      = $clog2(NUM_LEVELS + 1);
  localparam int SW         = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [LVL_W-1:0] LVL_IDLE   = LVL_W'(NUM_LEVELS);
  localparam logic [LVL_W-1:0] LVL_DEF    = LVL_W'(NUM_SLOTS);
  localparam logic [CNT_W-1:0] SWEEP_LAST = CNT_W'(NUM_SLOTS - 1);
  localparam logic [AW-1:0]    DEF_ADDR   = AW'(NUM_SLOTS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_APPLY  = 5'b00010,
    S_SWEEP  = 5'b00100,
    S_EXEC   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  // Control
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Captured item
  logic [1:0]  kind_r;
  logic [4:0]  line_r;
  logic        lvl_in_r;
  logic [11:0] off_r;
  logic [31:0] data_r;

  // Interrupt state
  logic [NUM_LINES-1:0] raw_r, raw_nxt;
  logic [NUM_LINES-1:0] soft_r, soft_nxt;
  logic [NUM_LINES-1:0] en_r, en_nxt;
  logic [NUM_LINES-1:0] fast_r, fast_nxt;
  logic                 prot_r, prot_nxt;
  logic [LVL_W-1:0]     cur_r, cur_nxt;
  logic [LVL_W-1:0]     saved_r [NUM_LEVELS];
  logic [LVL_W-1:0]     saved_nxt [NUM_LEVELS];

  // Read data staging and output register
  logic [31:0] rd_r, rd_nxt;
  logic        rd_mem_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_irq_r;
  logic        out_fiq_r;

  // Decode and misc
  logic                 in_fire;
  logic                 do_read, do_write;
  logic [9:0]           word;
  logic [5:0]           slot_sel;
  logic                 is_id, is_slot_addr, is_slot_ctl, is_reg;
  logic [NUM_LINES-1:0] pending;
  logic [NUM_LINES-1:0] wv;
  logic [NUM_LINES-1:0] lm;
  logic                 irq_nxt, fiq_nxt;
  logic                 out_load;
  logic [LVL_W-1:0]     tgt_lvl;
  logic                 tgt_ok;

  // Slot chain
  logic [NUM_LINES-1:0] acc_chain [NUM_LEVELS];
  vic_pkg::hit_t        hit_chain [NUM_LEVELS];
  logic [7:0]           ctl_bytes [NUM_SLOTS];
  vic_pkg::hit_t        last_hit;

  // Address store ports
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_rdata;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // Offset decode
  assign word         = off_r[11:2];
  assign slot_sel     = off_r[7:2];
  assign is_id        = (off_r >= vic_pkg::ID_BASE);
  assign is_slot_addr = (off_r[11:8] == vic_pkg::SLOT_ADDR_PAGE) && (int'(slot_sel) < NUM_SLOTS);
  assign is_slot_ctl  = (off_r[11:8] == vic_pkg::SLOT_CTL_PAGE) && (int'(slot_sel) < NUM_SLOTS);
  assign is_reg       = !is_id && !is_slot_addr && !is_slot_ctl;
  assign do_read      = (kind_r == vic_pkg::KIND_READ);
  assign do_write     = (kind_r == vic_pkg::KIND_WRITE);

  assign pending = raw_r | soft_r;
  assign wv      = data_r[NUM_LINES-1:0];

  // Slot cells
  assign acc_chain[0] = '0;
  assign hit_chain[0] = '0;

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    logic cell_we;
    assign cell_we = (state_r == S_APPLY) && do_write && is_slot_ctl && (int'(slot_sel) == k);

    vic_cell #(
      .NUM_LINES (NUM_LINES),
      .CELL_ID   (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_we    (cell_we),
      .ctl_wdata (data_r[7:0]),
      .pending   (pending),
      .acc_in    (acc_chain[k]),
      .hit_in    (hit_chain[k]),
      .acc_out   (acc_chain[k+1]),
      .hit_out   (hit_chain[k+1]),
      .ctl_out   (ctl_bytes[k])
    );
  end

  assign last_hit = hit_chain[NUM_SLOTS];

  // Register updates from line changes and bus writes
  always_comb begin
    raw_nxt  = raw_r;
    soft_nxt = soft_r;
    en_nxt   = en_r;
    fast_nxt = fast_r;
    prot_nxt = prot_r;
    if (state_r == S_APPLY) begin
      if (kind_r == vic_pkg::KIND_LINE) begin
        for (int i = 0; i < NUM_LINES; i++) begin
          if (int'(line_r) == i) begin
            raw_nxt[i] = lvl_in_r;
          end
        end
      end else if (do_write && is_reg) begin
        unique case (word)
          vic_pkg::W_INT_SELECT:   fast_nxt = wv;
          vic_pkg::W_INT_ENABLE:   en_nxt   = en_r | wv;
          vic_pkg::W_INT_EN_CLEAR: en_nxt   = en_r & ~wv;
          vic_pkg::W_SOFT_INT:     soft_nxt = soft_r | wv;
          vic_pkg::W_SOFT_CLEAR:   soft_nxt = soft_r & ~wv;
          vic_pkg::W_PROTECTION:   prot_nxt = data_r[0];
          default: ;
        endcase
      end
    end
  end

  // Vector address writes
  assign mem_we    = (state_r == S_APPLY) && do_write &&
                     (is_slot_addr || (is_reg && (word == vic_pkg::W_DEF_VECT)));
  assign mem_waddr = is_slot_addr ? AW'(slot_sel) : DEF_ADDR;

  // Highest pending level from the settled chain
  assign tgt_lvl = last_hit.found ? LVL_W'(last_hit.idx) : LVL_DEF;
  assign tgt_ok  = last_hit.found || (|pending);

  // Priority level: raise on vector read, restore on vector write
  always_comb begin
    cur_nxt   = cur_r;
    saved_nxt = saved_r;
    if ((state_r == S_EXEC) && is_reg && (word == vic_pkg::W_VECT_ADDR)) begin
      if (do_read && tgt_ok && (tgt_lvl < cur_r)) begin
        saved_nxt[tgt_lvl[AW-1:0]] = cur_r;
        cur_nxt                    = tgt_lvl;
      end else if (do_write && (cur_r < LVL_IDLE)) begin
        if (saved_r[cur_r[AW-1:0]] > LVL_IDLE) begin
          cur_nxt = LVL_IDLE;
        end else begin
          cur_nxt = saved_r[cur_r[AW-1:0]];
        end
      end
    end
  end

  // Vector address reads
  assign mem_re = (state_r == S_EXEC) && do_read &&
                  (is_slot_addr || (is_reg && ((word == vic_pkg::W_VECT_ADDR) ||
                                               (word == vic_pkg::W_DEF_VECT))));
  always_comb begin
    mem_raddr = DEF_ADDR;
    if (is_slot_addr) begin
      mem_raddr = AW'(slot_sel);
    end else if ((word == vic_pkg::W_VECT_ADDR) && (cur_nxt < LVL_IDLE)) begin
      mem_raddr = cur_nxt[AW-1:0];
    end
  end

  vic_addr_mem #(
    .DEPTH (NUM_LEVELS),
    .AW    (AW)
  ) u_addr_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (data_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Read data of everything outside the address store
  always_comb begin
    rd_nxt = '0;
    if (do_read) begin
      if (is_id) begin
        rd_nxt = 32'(vic_pkg::ID_BYTES[off_r[4:2]]);
      end else if (is_slot_ctl) begin
        rd_nxt = 32'(ctl_bytes[slot_sel[SW-1:0]]);
      end else if (is_reg) begin
        unique case (word)
          vic_pkg::W_IRQ_STATUS: rd_nxt = 32'(pending & en_r & ~fast_r);
          vic_pkg::W_FIQ_STATUS: rd_nxt = 32'(pending & fast_r);
          vic_pkg::W_RAW_INTR:   rd_nxt = 32'(pending);
          vic_pkg::W_INT_SELECT: rd_nxt = 32'(fast_r);
          vic_pkg::W_INT_ENABLE: rd_nxt = 32'(en_r);
          vic_pkg::W_SOFT_INT:   rd_nxt = 32'(soft_r);
          vic_pkg::W_PROTECTION: rd_nxt = 32'(prot_r);
          default:               rd_nxt = '0;
        endcase
      end
    end
  end

  // Priority mask of the current level
  always_comb begin
    if (cur_r <= LVL_DEF) begin
      lm = acc_chain[cur_r[AW-1:0]];
    end else begin
      lm = '1;
    end
  end

  assign irq_nxt  = |(pending & en_r & ~fast_r & lm);
  assign fiq_nxt  = |(pending & fast_r);
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        state_nxt = S_SWEEP;
        cnt_nxt   = '0;
      end
      S_SWEEP: begin
        if (cnt_r == SWEEP_LAST) begin
          state_nxt = S_EXEC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EXEC: state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and interrupt state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      raw_r       <= '0;
      soft_r      <= '0;
      en_r        <= '0;
      fast_r      <= '0;
      prot_r      <= 1'b0;
      cur_r       <= LVL_IDLE;
      rd_mem_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        saved_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      raw_r   <= raw_nxt;
      soft_r  <= soft_nxt;
      en_r    <= en_nxt;
      fast_r  <= fast_nxt;
      prot_r  <= prot_nxt;
      cur_r   <= cur_nxt;
      saved_r <= saved_nxt;
      if (state_r == S_EXEC) begin
        rd_mem_r <= mem_re;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= in_kind;
      line_r   <= in_line_index;
      lvl_in_r <= in_line_level;
      off_r    <= in_byte_offset;
      data_r   <= in_write_data;
    end
    if (state_r == S_EXEC) begin
      rd_r <= rd_nxt;
    end
    if (out_load) begin
      out_data_r <= rd_mem_r ? mem_rdata : rd_r;
      out_irq_r  <= irq_nxt;
      out_fiq_r  <= fiq_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_irq_out   = out_irq_r;
  assign out_fiq_out   = out_fiq_r;

  // Checks
  `VIC_ASSERT(a_level_range, cur_r <= LVL_IDLE, "priority level beyond idle")
  `VIC_ASSERT_NEXT(a_accept_apply, in_valid && in_ready, state_r == S_APPLY, "transfer did not start apply")
  `VIC_ASSERT_NEXT(a_level_hold, state_r != S_EXEC, cur_r == $past(cur_r), "level moved outside exec")
  `VIC_ASSERT_NEXT(a_read_raises, (state_r == S_EXEC) && do_read, cur_r <= $past(cur_r), "read lowered priority")
  `VIC_ASSERT_IMP(a_out_from_finish, $rose(out_valid_r), $past(state_r == S_FINISH), "result without finish")

endmodule

### tb/vic_response_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vic_response_checker
// Watches both channels of the interrupt controller. Every input transfer is
// run through a local copy of the controller state to produce the expected
// read data and IRQ/FIQ levels; every result transfer is compared against
// the oldest expectation in order.
// ----------------------------------------------------------------------------
module vic_response_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [4:0]  in_line_index,
  input  logic        in_line_level,
  input  logic [11:0] in_byte_offset,
  input  logic [31:0] in_write_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_read_data,
  input  logic        out_irq_out,
  input  logic        out_fiq_out,
  output int          mismatches,
  output int          backlog
);

  localparam int SLOTS  = vic_pkg::NUM_SLOTS_DEF;
  // Slot levels plus the default-vector level; LEVELS itself means idle
  localparam int LEVELS = SLOTS + 1;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        fiq;
  } vic_result_t;

  // Shadow of the controller state
  logic [31:0] raw_lines;
  logic [31:0] soft_lines;
  logic [31:0] enabled;
  logic [31:0] fiq_routed;
  logic        protect;
  logic [7:0]  slot_ctl [SLOTS];
  logic [31:0] vector_addr [LEVELS];
  int unsigned cur_level;
  int unsigned prior_level [LEVELS];

  vic_result_t awaited_results [$];
  vic_result_t want;
  int          i;

  // Sources of the enabled slots strictly above priority level lvl
  function automatic logic [31:0] sources_above(int unsigned lvl);
    logic [31:0] acc;
    int unsigned k;
    acc = '0;
    if (lvl > SLOTS) return '1;
    for (k = 0; k < lvl; k++) begin
      if (slot_ctl[k][vic_pkg::CTL_EN_BIT]) acc |= 32'd1 << slot_ctl[k][4:0];
    end
    return acc;
  endfunction

  // Apply one input item to the shadow state and return its result
  function automatic vic_result_t predict_response(logic [1:0] kind, logic [4:0] line,
                                                   logic lvl, logic [11:0] off,
                                                   logic [31:0] data);
    vic_result_t res;
    logic [31:0] pend;
    logic [9:0]  word;
    int unsigned slot;
    int unsigned k;
    res  = '0;
    word = off[11:2];
    slot = {26'd0, off[7:2]};
    case (kind)
      vic_pkg::KIND_LINE: raw_lines[line] = lvl;
      vic_pkg::KIND_READ: begin
        if (off >= vic_pkg::ID_BASE) begin
          res.read_data = {24'd0, vic_pkg::ID_BYTES[off[4:2]]};
        end else if (off[11:8] == vic_pkg::SLOT_ADDR_PAGE && slot < SLOTS) begin
          res.read_data = vector_addr[slot];
        end else if (off[11:8] == vic_pkg::SLOT_CTL_PAGE && slot < SLOTS) begin
          res.read_data = {24'd0, slot_ctl[slot]};
        end else begin
          pend = raw_lines | soft_lines;
          case (word)
            vic_pkg::W_IRQ_STATUS: res.read_data = pend & enabled & ~fiq_routed;
            vic_pkg::W_FIQ_STATUS: res.read_data = pend & fiq_routed;
            vic_pkg::W_RAW_INTR:   res.read_data = pend;
            vic_pkg::W_INT_SELECT: res.read_data = fiq_routed;
            vic_pkg::W_INT_ENABLE: res.read_data = enabled;
            vic_pkg::W_SOFT_INT:   res.read_data = soft_lines;
            vic_pkg::W_PROTECTION: res.read_data = {31'd0, protect};
            vic_pkg::W_DEF_VECT:   res.read_data = vector_addr[SLOTS];
            vic_pkg::W_VECT_ADDR: begin
              // Find the highest level with a pending source above current
              k = 0;
              while (k < cur_level && k < LEVELS && (pend & sources_above(k + 1)) == 0)
                k++;
              if (k < LEVELS && k < cur_level) begin
                prior_level[k] = cur_level;
                cur_level      = k;
              end
              res.read_data = (cur_level >= LEVELS) ? vector_addr[SLOTS]
                                                    : vector_addr[cur_level];
            end
            default: res.read_data = '0;
          endcase
        end
      end
      vic_pkg::KIND_WRITE: begin
        if (off >= vic_pkg::ID_BASE) begin
          // ID window is read only
        end else if (off[11:8] == vic_pkg::SLOT_ADDR_PAGE && slot < SLOTS) begin
          vector_addr[slot] = data;
        end else if (off[11:8] == vic_pkg::SLOT_CTL_PAGE && slot < SLOTS) begin
          slot_ctl[slot] = data[7:0];
        end else begin
          case (word)
            vic_pkg::W_INT_SELECT:   fiq_routed = data;
            vic_pkg::W_INT_ENABLE:   enabled    = enabled | data;
            vic_pkg::W_INT_EN_CLEAR: enabled    = enabled & ~data;
            vic_pkg::W_SOFT_INT:     soft_lines = soft_lines | data;
            vic_pkg::W_SOFT_CLEAR:   soft_lines = soft_lines & ~data;
            vic_pkg::W_PROTECTION:   protect    = data[0];
            vic_pkg::W_DEF_VECT:     vector_addr[SLOTS] = data;
            vic_pkg::W_VECT_ADDR: begin
              // End of service: back to the level that was interrupted
              if (cur_level < LEVELS)
                cur_level = (prior_level[cur_level] > LEVELS) ? LEVELS
                                                              : prior_level[cur_level];
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    pend    = raw_lines | soft_lines;
    res.irq = |(pend & enabled & ~fiq_routed & sources_above(cur_level));
    res.fiq = |(pend & fiq_routed);
    return res;
  endfunction

  // Scoreboard: check result transfers, queue predictions for input transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      raw_lines  = '0;
      soft_lines = '0;
      enabled    = '0;
      fiq_routed = '0;
      protect    = 1'b0;
      cur_level  = LEVELS;
      mismatches = 0;
      for (i = 0; i < SLOTS; i++) slot_ctl[i] = '0;
      for (i = 0; i < LEVELS; i++) begin
        vector_addr[i] = '0;
        prior_level[i] = 0;
      end
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing outstanding: read_data %h", out_read_data);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_read_data !== want.read_data) begin
            $error("read_data mismatch: expected %h, actual %h", want.read_data, out_read_data);
            mismatches++;
          end
          if (out_irq_out !== want.irq) begin
            $error("irq_out mismatch: expected %b, actual %b", want.irq, out_irq_out);
            mismatches++;
          end
          if (out_fiq_out !== want.fiq) begin
            $error("fiq_out mismatch: expected %b, actual %b", want.fiq, out_fiq_out);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(predict_response(in_kind, in_line_index, in_line_level,
                                                   in_byte_offset, in_write_data));
    end
    backlog <= awaited_results.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives line changes and register reads/writes into the vectored interrupt
// controller: a directed pass over register extremes and corner cases, then
// random interrupt service sequences mixed with register traffic and noise.
// Both channels stall at random; the checker beside the block does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] KIND_UNUSED     = 2'd3;
  localparam logic [9:0] W_UNUSED        = 10'd9;
  localparam logic [7:0] SLOT_WINDOW_END = 8'h40;
  localparam int         SLOTS           = vic_pkg::NUM_SLOTS_DEF;
  localparam int         TOTAL_ITEMS     = 2000;
  localparam int         PHASE_ITEMS     = 150;
  localparam int         HOLD_AFTER      = 600;
  localparam int         HOLD_OFF_CYCLES = 400;
  localparam int         DRAIN_CYCLES    = 60;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind        = vic_pkg::KIND_LINE;
  logic [4:0]  in_line_index  = '0;
  logic        in_line_level  = 1'b0;
  logic [11:0] in_byte_offset = '0;
  logic [31:0] in_write_data  = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [31:0] out_read_data;
  logic        out_irq_out;
  logic        out_fiq_out;

  int mismatches;
  int backlog;
  int items_sent = 0;
  bit calm       = 1'b0;
  bit hold_done  = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  vectored_interrupt_controller dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_line_index  (in_line_index),
    .in_line_level  (in_line_level),
    .in_byte_offset (in_byte_offset),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_irq_out    (out_irq_out),
    .out_fiq_out    (out_fiq_out)
  );

  vic_response_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_line_index  (in_line_index),
    .in_line_level  (in_line_level),
    .in_byte_offset (in_byte_offset),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_irq_out    (out_irq_out),
    .out_fiq_out    (out_fiq_out),
    .mismatches     (mismatches),
    .backlog        (backlog)
  );

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(16, 40);
  endfunction

  // Lines cluster on a few sources so slots actually match
  function automatic logic [4:0] pick_line();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom & 32'hFF;
      default: return 32'd1 << pick_line();
    endcase
  endfunction

  function automatic logic [7:0] pick_ctl();
    logic [7:0] c;
    c                      = 8'($urandom);
    c[vic_pkg::CTL_EN_BIT] = ($urandom_range(0, 4) != 0);
    c[4:0]                 = pick_line();
    return c;
  endfunction

  // Register offset with random (ignored) byte lane bits
  function automatic logic [11:0] reg_off(logic [9:0] word);
    logic [1:0] lane;
    lane = 2'($urandom);
    return {word, lane};
  endfunction

  function automatic logic [11:0] slot_off(logic [3:0] page, logic [3:0] idx);
    return {page, 2'b00, idx, 2'b00};
  endfunction

  // One input transfer; valid stays up across back-to-back items
  task automatic send_item(input logic [1:0] kind, input logic [4:0] line,
                           input logic lvl, input logic [11:0] off,
                           input logic [31:0] data);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_line_index  <= line;
    in_line_level  <= lvl;
    in_byte_offset <= off;
    in_write_data  <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic bus_rd(input logic [11:0] off);
    send_item(vic_pkg::KIND_READ, 5'($urandom), 1'($urandom), off, $urandom);
  endtask

  task automatic bus_wr(input logic [11:0] off, input logic [31:0] data);
    send_item(vic_pkg::KIND_WRITE, 5'($urandom), 1'($urandom), off, data);
  endtask

  task automatic line_chg(input logic [4:0] line, input logic lvl);
    send_item(vic_pkg::KIND_LINE, line, lvl, 12'($urandom), $urandom);
  endtask

  // Sender pause until every outstanding result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  task automatic program_slots();
    logic [31:0] rnd;
    int          k;
    for (k = 0; k < SLOTS; k++) begin
      rnd = $urandom;
      bus_wr(slot_off(vic_pkg::SLOT_CTL_PAGE, 4'(k)), {rnd[31:8], pick_ctl()});
      bus_wr(slot_off(vic_pkg::SLOT_ADDR_PAGE, 4'(k)), $urandom);
    end
  endtask

  // Interrupt service: assert, fetch vector, maybe nest, acknowledge, clear
  task automatic service_burst();
    logic [4:0] first;
    logic [4:0] second;
    bit         by_soft;
    first   = pick_line();
    by_soft = ($urandom_range(0, 3) == 0);
    if (by_soft) bus_wr(reg_off(vic_pkg::W_SOFT_INT), 32'd1 << first);
    else line_chg(first, 1'b1);
    bus_rd(reg_off(vic_pkg::W_VECT_ADDR));
    if ($urandom_range(0, 1)) bus_rd(reg_off(vic_pkg::W_IRQ_STATUS));
    if ($urandom_range(0, 2) == 0) begin
      second = pick_line();
      line_chg(second, 1'b1);
      bus_rd(reg_off(vic_pkg::W_VECT_ADDR));
      bus_wr(reg_off(vic_pkg::W_VECT_ADDR), $urandom);
      line_chg(second, 1'b0);
    end
    // occasionally the handler forgets to acknowledge
    if ($urandom_range(0, 9) != 0) bus_wr(reg_off(vic_pkg::W_VECT_ADDR), $urandom);
    if (by_soft) bus_wr(reg_off(vic_pkg::W_SOFT_CLEAR), 32'd1 << first);
    else line_chg(first, 1'b0);
  endtask

  task automatic random_item();
    int unsigned r;
    logic [31:0] rnd;
    r   = $urandom_range(0, 99);
    rnd = $urandom;
    if (r < 18) begin
      line_chg(pick_line(), 1'($urandom));
    end else if (r < 42) begin
      case ($urandom_range(0, 9))
        0: bus_rd(reg_off(vic_pkg::W_IRQ_STATUS));
        1: bus_rd(reg_off(vic_pkg::W_FIQ_STATUS));
        2: bus_rd(reg_off(vic_pkg::W_RAW_INTR));
        3: bus_rd(reg_off(vic_pkg::W_INT_SELECT));
        4: bus_rd(reg_off(vic_pkg::W_INT_ENABLE));
        5: bus_rd(reg_off(vic_pkg::W_SOFT_INT));
        6: bus_rd(reg_off(vic_pkg::W_PROTECTION));
        7: bus_rd(reg_off(vic_pkg::W_DEF_VECT));
        8: bus_rd(slot_off($urandom_range(0, 1) ? vic_pkg::SLOT_ADDR_PAGE
                                                : vic_pkg::SLOT_CTL_PAGE, 4'($urandom)));
        default: bus_rd(vic_pkg::ID_BASE + 12'($urandom_range(0, 31)));
      endcase
    end else if (r < 70) begin
      case ($urandom_range(0, 10))
        0: bus_wr(reg_off(vic_pkg::W_INT_ENABLE), pick_mask());
        1: bus_wr(reg_off(vic_pkg::W_INT_EN_CLEAR), pick_mask());
        2: bus_wr(reg_off(vic_pkg::W_SOFT_INT), pick_mask());
        3: bus_wr(reg_off(vic_pkg::W_SOFT_CLEAR), pick_mask());
        4: bus_wr(reg_off(vic_pkg::W_INT_SELECT),
                  $urandom_range(0, 1) ? 32'd0 : 32'd1 << pick_line());
        5: bus_wr(reg_off(vic_pkg::W_PROTECTION), rnd);
        6: bus_wr(reg_off(vic_pkg::W_DEF_VECT), rnd);
        7: bus_wr(reg_off(vic_pkg::W_VECT_ADDR), rnd);
        8: bus_wr(slot_off(vic_pkg::SLOT_ADDR_PAGE, 4'($urandom)), rnd);
        9: bus_wr(slot_off(vic_pkg::SLOT_CTL_PAGE, 4'($urandom)), {rnd[31:8], pick_ctl()});
        default: bus_wr(reg_off(10'($urandom_range(vic_pkg::W_IRQ_STATUS,
                                                   vic_pkg::W_RAW_INTR))), rnd);
      endcase
    end else if (r < 88) begin
      bus_rd(reg_off(vic_pkg::W_VECT_ADDR));
    end else if (r < 94) begin
      // noise: any offset at all
      if ($urandom_range(0, 1)) bus_rd(12'($urandom));
      else bus_wr(12'($urandom), rnd);
    end else begin
      send_item(KIND_UNUSED, 5'($urandom), 1'($urandom), 12'($urandom), rnd);
    end
  endtask

  // Result side: random stalls, plus one long hold-off to back up the block
  initial begin
    int unsigned stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, calm ? 200 : 24)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int next_phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ID window, idle vector handling, extremes, bad offsets
    bus_rd(vic_pkg::ID_BASE);
    bus_rd(vic_pkg::ID_BASE + 12'h00B);
    bus_rd(vic_pkg::ID_BASE + 12'h01F);
    bus_rd(reg_off(vic_pkg::W_VECT_ADDR));
    bus_wr(reg_off(vic_pkg::W_VECT_ADDR), 32'hFFFF_FFFF);
    bus_wr(reg_off(vic_pkg::W_DEF_VECT), 32'hFFFF_FFFF);
    bus_rd(reg_off(vic_pkg::W_DEF_VECT));
    bus_wr(slot_off(vic_pkg::SLOT_ADDR_PAGE, 4'd0), 32'hFFFF_FFFF);
    bus_wr(slot_off(vic_pkg::SLOT_CTL_PAGE, 4'd15), 32'hFFFF_FFFF);
    bus_rd(slot_off(vic_pkg::SLOT_CTL_PAGE, 4'd15));
    bus_wr(reg_off(vic_pkg::W_INT_ENABLE), 32'hFFFF_FFFF);
    line_chg(5'd31, 1'b1);
    bus_rd(reg_off(vic_pkg::W_IRQ_STATUS));
    bus_rd(reg_off(vic_pkg::W_VECT_ADDR));
    bus_wr(reg_off(vic_pkg::W_SOFT_INT), 32'h0000_0001);
    bus_rd(reg_off(vic_pkg::W_VECT_ADDR));
    bus_wr(reg_off(vic_pkg::W_VECT_ADDR), 32'd0);
    bus_wr(reg_off(vic_pkg::W_VECT_ADDR), 32'd0);
    bus_wr(reg_off(vic_pkg::W_INT_SELECT), 32'hFFFF_FFFF);
    bus_rd(reg_off(vic_pkg::W_FIQ_STATUS));
    bus_wr(reg_off(vic_pkg::W_INT_SELECT), 32'd0);
    bus_rd(reg_off(W_UNUSED));
    bus_wr({vic_pkg::SLOT_ADDR_PAGE, SLOT_WINDOW_END}, 32'hFFFF_FFFF);
    bus_rd({vic_pkg::SLOT_CTL_PAGE, SLOT_WINDOW_END});
    bus_wr(vic_pkg::ID_BASE, 32'hFFFF_FFFF);
    send_item(KIND_UNUSED, 5'd31, 1'b1, 12'hFFF, 32'hFFFF_FFFF);
    line_chg(5'd0, 1'b1);
    bus_wr(reg_off(vic_pkg::W_PROTECTION), 32'hFFFF_FFFF);
    bus_rd(reg_off(vic_pkg::W_PROTECTION));
    bus_rd(reg_off(vic_pkg::W_RAW_INTR));
    bus_wr(reg_off(vic_pkg::W_SOFT_CLEAR), 32'hFFFF_FFFF);
    bus_wr(reg_off(vic_pkg::W_INT_EN_CLEAR), 32'hFFFF_FFFF);
    drain_results();

    // Random: program all slots, then service sequences mixed with traffic
    program_slots();
    bus_wr(reg_off(vic_pkg::W_INT_ENABLE), 32'h0000_00FF | $urandom);
    next_phase = items_sent + PHASE_ITEMS;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= next_phase) begin
        next_phase = items_sent + PHASE_ITEMS;
        calm       = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
          0:       drain_results();
          1:       program_slots();
          default: ;
        endcase
      end
      if ($urandom_range(0, 99) < 35) service_burst();
      else random_item();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("vectored_interrupt_controller verification clean");
    else
      $display("vectored_interrupt_controller verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("vectored_interrupt_controller verification failed");
    $finish;
  end

endmodule
